### sv/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg: shared types and constants for the permutation rank/unrank block
// Factorial weights, field widths and the pipeline stage word.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int NPOS    = 9;
  localparam int DIGIT_W = 4;
  localparam int RANK_W  = 19;
  localparam int CNT_W   = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 19'd362880;

  typedef enum logic {
    FUNC_RANK   = 1'b0,
    FUNC_UNRANK = 1'b1
  } func_t;

  // n! for n in 0..9
  function automatic logic [RANK_W-1:0] fact(input int n);
    logic [RANK_W-1:0] f;
    case (n)
      0:       f = 19'd1;
      1:       f = 19'd1;
      2:       f = 19'd2;
      3:       f = 19'd6;
      4:       f = 19'd24;
      5:       f = 19'd120;
      6:       f = 19'd720;
      7:       f = 19'd5040;
      8:       f = 19'd40320;
      9:       f = 19'd362880;
      default: f = 19'd0;
    endcase
    return f;
  endfunction

  // One pipeline word: both directions travel together, the output picks.
  typedef struct packed {
    func_t                             func;
    logic                              err;
    logic [RANK_W-1:0]                 rest;
    logic [RANK_W-1:0]                 acc;
    logic [NPOS-1:0]                   used;
    logic [NPOS-1:0][CNT_W-1:0]        cnt;
    logic [NPOS-1:0][DIGIT_W-1:0]      dig;
  } stage_t;

endpackage

### sv/permutation_rank_unrank.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank: Cantor-expansion rank / unrank of nine digits
// One word can enter every cycle while busy is low. A word passes the entry
// register, the nine factorial stages (one per digit position) and the
// output register. The output cannot stall.
// Synchronous active-low reset clears valid bits; busy is high during reset
// and is cleared by the first clock edge with rst_n high, then stays low.
// ----------------------------------------------------------------------------
module permutation_rank_unrank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [pru_pkg::RANK_W-1:0]    in_rank_in,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_0,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_1,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_2,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_3,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_4,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_5,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_6,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_7,
  input  logic [pru_pkg::DIGIT_W-1:0]   in_digit_in_8,
  output logic                          out_valid,
  output logic [pru_pkg::RANK_W-1:0]    out_rank_out,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_0,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_1,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_2,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_3,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_4,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_5,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_6,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_7,
  output logic [pru_pkg::DIGIT_W-1:0]   out_digit_out_8,
  output logic                          out_range_error
);

  import pru_pkg::*;

  // --------------------------------------------------------------------------
  // Handshake: the pipeline never stalls, so busy only covers reset.
  // --------------------------------------------------------------------------
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // --------------------------------------------------------------------------
  // Entry stage: count later smaller digits for every position (rank), form
  // the zero-based rank and the range check (unrank).
  // --------------------------------------------------------------------------
  logic [NPOS-1:0][DIGIT_W-1:0] din;
  stage_t                       entry_nxt;

  assign din = {in_digit_in_8, in_digit_in_7, in_digit_in_6, in_digit_in_5,
                in_digit_in_4, in_digit_in_3, in_digit_in_2, in_digit_in_1,
                in_digit_in_0};

  always_comb begin
    entry_nxt      = '0;
    entry_nxt.func = func_t'(in_func);
    entry_nxt.err  = (in_rank_in == '0) || (in_rank_in > RANK_MAX);
    entry_nxt.rest = in_rank_in - 19'd1;
    entry_nxt.acc  = 19'd1;                 // one-based rank
    for (int i = 0; i < NPOS; i++) begin
      for (int j = i + 1; j < NPOS; j++) begin
        if (din[j] < din[i]) begin
          entry_nxt.cnt[i] = entry_nxt.cnt[i] + 4'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Digit stages: stage k handles position k in both directions.
  //   rank:   acc += cnt[k] * (8-k)!
  //   unrank: q = rest / (8-k)!, rest -= q * (8-k)!, take the q-th free digit
  // --------------------------------------------------------------------------
  stage_t          pipe_r   [0:NPOS];
  stage_t          pipe_nxt [1:NPOS];
  logic [NPOS:0]   vld_r;

  for (genvar k = 0; k < NPOS; k++) begin : g_stage
    localparam logic [RANK_W-1:0] W = fact(NPOS - 1 - k);

    always_comb begin
      logic [CNT_W-1:0]  q;
      logic [RANK_W-1:0] qw;
      logic [CNT_W-1:0]  below;
      logic              found;
      pipe_nxt[k+1] = pipe_r[k];
      // Rest stays below 9 * W, so the quotient is a count of passed multiples.
      q = '0;
      for (int m = 1; m < NPOS; m++) begin
        if (pipe_r[k].rest >= RANK_W'(m * W)) begin
          q = q + 4'd1;
        end
      end
      qw = W * RANK_W'(q);
      pipe_nxt[k+1].rest = pipe_r[k].rest - qw;
      pipe_nxt[k+1].acc  = pipe_r[k].acc + RANK_W'(W * RANK_W'(pipe_r[k].cnt[k]));
      // Pick the free digit with exactly q free digits below it.
      found = 1'b0;
      pipe_nxt[k+1].dig[k] = '0;
      for (int j = 0; j < NPOS; j++) begin
        below = '0;
        for (int i = 0; i < j; i++) begin
          if (!pipe_r[k].used[i]) begin
            below = below + 4'd1;
          end
        end
        if (!found && !pipe_r[k].used[j] && below == q) begin
          found                 = 1'b1;
          pipe_nxt[k+1].dig[k]  = DIGIT_W'(j);
          pipe_nxt[k+1].used[j] = 1'b1;
        end
      end
    end
  end

  // Advance every stage each cycle; valid bits carry the occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NPOS-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    pipe_r[0] <= entry_nxt;
    for (int s = 1; s <= NPOS; s++) begin
      pipe_r[s] <= pipe_nxt[s];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: drop the direction that was not asked for, zero the
  // digits on a range error.
  // --------------------------------------------------------------------------
  logic                         out_valid_r;
  logic [RANK_W-1:0]            out_rank_r;
  logic [NPOS-1:0][DIGIT_W-1:0] out_dig_r;
  logic                         out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NPOS];
    end
  end

  always_ff @(posedge clk) begin
    case (pipe_r[NPOS].func)
      FUNC_RANK: begin
        out_rank_r <= pipe_r[NPOS].acc;
        out_dig_r  <= '0;
        out_err_r  <= 1'b0;
      end
      FUNC_UNRANK: begin
        out_rank_r <= '0;
        out_dig_r  <= pipe_r[NPOS].err ? '0 : pipe_r[NPOS].dig;
        out_err_r  <= pipe_r[NPOS].err;
      end
      default: begin
        out_rank_r <= '0;
        out_dig_r  <= '0;
        out_err_r  <= 1'b0;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_rank_out    = out_rank_r;
  assign out_digit_out_0 = out_dig_r[0];
  assign out_digit_out_1 = out_dig_r[1];
  assign out_digit_out_2 = out_dig_r[2];
  assign out_digit_out_3 = out_dig_r[3];
  assign out_digit_out_4 = out_dig_r[4];
  assign out_digit_out_5 = out_dig_r[5];
  assign out_digit_out_6 = out_dig_r[6];
  assign out_digit_out_7 = out_dig_r[7];
  assign out_digit_out_8 = out_dig_r[8];
  assign out_range_error = out_err_r;

`ifndef SYNTHESIS
  // Every accepted word comes out through the entry register, the digit stages and the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##11 out_valid)
    else $error("accepted word did not come out after 11 cycles");

  // No result without a matching word accepted at the pipeline entry.
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 11))
    else $error("result without a matching accepted word");

  // A range error carries no rank and no digits.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_rank_out == '0 && out_dig_r == '0))
    else $error("range error with nonzero payload");

  // The rank never passes 9!.
  a_rank_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rank_out <= RANK_MAX))
    else $error("rank above 362880");
`endif

endmodule
